@@ rtl/rmd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIPEMD-160 compression package
// Round tables, constants, boolean functions and payload types.
// ----------------------------------------------------------------------------
package rmd_pkg;

   localparam int unsigned WordWidth  = 32;
   localparam int unsigned BlockWords = 16;
   localparam int unsigned RoundCount = 80;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [3:0]           widx_type;
   typedef logic [6:0]           round_type;
   typedef logic [2:0]           group_type;
   typedef logic [3:0]           rot_type;

   typedef struct packed {
      word_type msg_word;
      logic     new_message;
   } req_type;

   typedef struct packed {
      word_type hash_w0;
      word_type hash_w1;
      word_type hash_w2;
      word_type hash_w3;
      word_type hash_w4;
   } rsp_type;

   localparam word_type Iv0 = 32'h67452301;
   localparam word_type Iv1 = 32'hefcdab89;
   localparam word_type Iv2 = 32'h98badcfe;
   localparam word_type Iv3 = 32'h10325476;
   localparam word_type Iv4 = 32'hc3d2e1f0;

   localparam logic [4*80-1:0] LeftWord = {
      4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15,
      4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,4'd8,
      4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,4'd12,
      4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,4'd2,
      4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,4'd13};
   localparam logic [4*80-1:0] RightWord = {
      4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,4'd12,
      4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,4'd2,
      4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,4'd13,
      4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,4'd14,
      4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,4'd11};
   localparam logic [4*80-1:0] LeftRot = {
      4'd11,4'd14,4'd15,4'd12,4'd5,4'd8,4'd7,4'd9,4'd11,4'd13,4'd14,4'd15,4'd6,4'd7,4'd9,4'd8,
      4'd7,4'd6,4'd8,4'd13,4'd11,4'd9,4'd7,4'd15,4'd7,4'd12,4'd15,4'd9,4'd11,4'd7,4'd13,4'd12,
      4'd11,4'd13,4'd6,4'd7,4'd14,4'd9,4'd13,4'd15,4'd14,4'd8,4'd13,4'd6,4'd5,4'd12,4'd7,4'd5,
      4'd11,4'd12,4'd14,4'd15,4'd14,4'd15,4'd9,4'd8,4'd9,4'd14,4'd5,4'd6,4'd8,4'd6,4'd5,4'd12,
      4'd9,4'd15,4'd5,4'd11,4'd6,4'd8,4'd13,4'd12,4'd5,4'd12,4'd13,4'd14,4'd11,4'd8,4'd5,4'd6};
   localparam logic [4*80-1:0] RightRot = {
      4'd8,4'd9,4'd9,4'd11,4'd13,4'd15,4'd15,4'd5,4'd7,4'd7,4'd8,4'd11,4'd14,4'd14,4'd12,4'd6,
      4'd9,4'd13,4'd15,4'd7,4'd12,4'd8,4'd9,4'd11,4'd7,4'd7,4'd12,4'd7,4'd6,4'd15,4'd13,4'd11,
      4'd9,4'd7,4'd15,4'd11,4'd8,4'd6,4'd6,4'd14,4'd12,4'd13,4'd5,4'd14,4'd13,4'd13,4'd7,4'd5,
      4'd15,4'd5,4'd8,4'd11,4'd14,4'd14,4'd6,4'd14,4'd6,4'd9,4'd12,4'd9,4'd12,4'd5,4'd15,4'd8,
      4'd8,4'd5,4'd12,4'd9,4'd12,4'd5,4'd14,4'd6,4'd8,4'd13,4'd6,4'd5,4'd15,4'd13,4'd11,4'd11};

   // Entry 0 sits in the top nibble.
   function automatic logic [3:0] tbl_get(input logic [4*80-1:0] tbl, input round_type j);
      logic [6:0] k;
      k = 7'(RoundCount - 1) - j;
      return tbl[k*4 +: 4];
   endfunction

   function automatic word_type left_k(input group_type g);
      word_type k;
      unique case (g)
         3'd0:    k = 32'h00000000;
         3'd1:    k = 32'h5a827999;
         3'd2:    k = 32'h6ed9eba1;
         3'd3:    k = 32'h8f1bbcdc;
         default: k = 32'ha953fd4e;
      endcase
      return k;
   endfunction

   function automatic word_type right_k(input group_type g);
      word_type k;
      unique case (g)
         3'd0:    k = 32'h50a28be6;
         3'd1:    k = 32'h5c4dd124;
         3'd2:    k = 32'h6d703ef3;
         3'd3:    k = 32'h7a6d76e9;
         default: k = 32'h00000000;
      endcase
      return k;
   endfunction

   function automatic word_type mix(input group_type g, input word_type x,
                                    input word_type y, input word_type z);
      word_type f;
      unique case (g)
         3'd0:    f = x ^ y ^ z;
         3'd1:    f = (x & y) | (~x & z);
         3'd2:    f = (x | ~y) ^ z;
         3'd3:    f = (x & z) | (y & ~z);
         default: f = x ^ (y | ~z);
      endcase
      return f;
   endfunction

   function automatic word_type rotl(input word_type x, input logic [4:0] n);
      logic [2*WordWidth-1:0] d;
      d = {x, x} << n;
      return d[2*WordWidth-1 -: WordWidth];
   endfunction

endpackage

@@ rtl/rmd_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of type payload_type per transfer.
// ----------------------------------------------------------------------------
interface rmd_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/ripemd160_block_compress.sv @@
`timescale 1ns / 1ps
// A word that does not complete a block is absorbed at its transfer.
// The sixteenth word starts the rounds (one round of both lines per cycle
// in the shared round unit), then the final add, then the result.
// Words of the next block are not taken until the result has been sent.
// Reset: synchronous, clears the word count and loads the initial chaining value.
// ----------------------------------------------------------------------------
// RIPEMD-160 block compression
// Buffers sixteen message words and runs the two-line compression round by
// round on one shared round unit, then presents the new chaining value.
// ----------------------------------------------------------------------------
module ripemd160_block_compress (
   input logic clock,
   input logic reset,
   rmd_stream_if.sink   req,
   rmd_stream_if.source rsp
);
   import rmd_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FINAL = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   widx_type  held_ff, held_in;
   round_type round_ff, round_in;
   word_type  chain_ff [5];
   word_type  chain_in [5];
   word_type  block_ff [BlockWords];
   // Working registers of both lines: a..e left, a2..e2 right.
   word_type  wl_ff [5];
   word_type  wl_in [5];
   word_type  wr_ff [5];
   word_type  wr_in [5];
   rsp_type   rsp_ff;

   logic      req_xfer;
   widx_type  wr_idx;
   group_type grp;
   word_type  tl, tr;

   assign req.ready   = (state_ff == ST_LOAD);
   assign req_xfer    = req.valid & req.ready;
   assign rsp.valid   = (state_ff == ST_SEND);
   assign rsp.payload = rsp_ff;

   // New-message words land at slot zero.
   assign wr_idx = req.payload.new_message ? '0 : held_ff;
   assign grp    = group_type'(round_ff >> 4);

   // Shared round unit: one step of each line.
   always_comb begin
      tl = wl_ff[0] + mix(grp, wl_ff[1], wl_ff[2], wl_ff[3])
         + block_ff[tbl_get(LeftWord, round_ff)] + left_k(grp);
      tl = rotl(tl, {1'b0, tbl_get(LeftRot, round_ff)}) + wl_ff[4];
      tr = wr_ff[0] + mix(3'd4 - grp, wr_ff[1], wr_ff[2], wr_ff[3])
         + block_ff[tbl_get(RightWord, round_ff)] + right_k(grp);
      tr = rotl(tr, {1'b0, tbl_get(RightRot, round_ff)}) + wr_ff[4];
   end

   always_comb begin
      state_in = state_ff;
      held_in  = held_ff;
      round_in = round_ff;
      chain_in = chain_ff;
      wl_in    = wl_ff;
      wr_in    = wr_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               if (req.payload.new_message) begin
                  chain_in = '{Iv0, Iv1, Iv2, Iv3, Iv4};
               end
               held_in = wr_idx + 4'd1;
               if (wr_idx == 4'(BlockWords - 1)) begin
                  // Seed both lines from the chaining value in effect.
                  wl_in    = chain_in;
                  wr_in    = chain_in;
                  round_in = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            wl_in = '{wl_ff[4], tl, wl_ff[1], rotl(wl_ff[2], 5'd10), wl_ff[3]};
            wr_in = '{wr_ff[4], tr, wr_ff[1], rotl(wr_ff[2], 5'd10), wr_ff[3]};
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(RoundCount - 1)) state_in = ST_FINAL;
         end
         ST_FINAL: begin
            chain_in[0] = chain_ff[1] + wl_ff[2] + wr_ff[3];
            chain_in[1] = chain_ff[2] + wl_ff[3] + wr_ff[4];
            chain_in[2] = chain_ff[3] + wl_ff[4] + wr_ff[0];
            chain_in[3] = chain_ff[4] + wl_ff[0] + wr_ff[1];
            chain_in[4] = chain_ff[0] + wl_ff[1] + wr_ff[2];
            state_in    = ST_SEND;
         end
         ST_SEND: begin
            if (rsp.ready) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         held_ff  <= '0;
         round_ff <= '0;
         chain_ff <= '{Iv0, Iv1, Iv2, Iv3, Iv4};
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   // Payload: block buffer, working lines, result hold.
   always_ff @(posedge clock) begin
      if (req_xfer) block_ff[wr_idx] <= req.payload.msg_word;
      wl_ff <= wl_in;
      wr_ff <= wr_in;
      if (state_ff == ST_FINAL) begin
         rsp_ff <= {chain_in[0], chain_in[1], chain_in[2], chain_in[3], chain_in[4]};
      end
   end

`ifndef SYNTHESIS
   // Advance from rounds to the final add only after the last round.
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && state_in == ST_FINAL) |-> round_ff == 7'(RoundCount - 1))
      else $error("round count off at final add");
   // Hold the result until the transfer.
   a_send_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEND && !rsp.ready) |=> state_ff == ST_SEND && $stable(rsp_ff))
      else $error("result dropped before transfer");
   // The word count wraps to zero when a block starts.
   a_block_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && state_in == ST_ROUND) |=> held_ff == '0)
      else $error("word count not wrapped");
`endif

endmodule

@@ tb/tb_ripemd160_block_compress.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIPEMD-160 block compression testbench
// Streams message words with random burst gaps and response stalls, predicts
// each chaining value with an independent software compression and compares
// every digest transfer field by field.
// ----------------------------------------------------------------------------

class digest_board;
   rmd_pkg::word_type chain[5];
   rmd_pkg::word_type words[16];
   int unsigned       fill;
   rmd_pkg::rsp_type  pending[$];
   int unsigned       errors;

   localparam rmd_pkg::word_type IvTab[5] = '{32'h67452301, 32'hefcdab89,
      32'h98badcfe, 32'h10325476, 32'hc3d2e1f0};
   localparam byte LWord[80] = '{
      0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15, 7,4,13,1,10,6,15,3,12,0,9,5,2,14,11,8,
      3,10,14,4,9,15,8,1,2,7,0,6,13,11,5,12, 1,9,11,10,0,8,12,4,13,3,7,15,14,5,6,2,
      4,0,5,9,7,12,2,10,14,1,3,8,11,6,15,13};
   localparam byte RWord[80] = '{
      5,14,7,0,9,2,11,4,13,6,15,8,1,10,3,12, 6,11,3,7,0,13,5,10,14,15,8,12,4,9,1,2,
      15,5,1,3,7,14,6,9,11,8,12,2,10,0,4,13, 8,6,4,1,3,11,15,0,5,12,2,13,9,7,10,14,
      12,15,10,4,1,5,8,7,6,2,13,14,0,3,9,11};
   localparam byte LRot[80] = '{
      11,14,15,12,5,8,7,9,11,13,14,15,6,7,9,8, 7,6,8,13,11,9,7,15,7,12,15,9,11,7,13,12,
      11,13,6,7,14,9,13,15,14,8,13,6,5,12,7,5, 11,12,14,15,14,15,9,8,9,14,5,6,8,6,5,12,
      9,15,5,11,6,8,13,12,5,12,13,14,11,8,5,6};
   localparam byte RRot[80] = '{
      8,9,9,11,13,15,15,5,7,7,8,11,14,14,12,6, 9,13,15,7,12,8,9,11,7,7,12,7,6,15,13,11,
      9,7,15,11,8,6,6,14,12,13,5,14,13,13,7,5, 15,5,8,11,14,14,6,14,6,9,12,9,12,5,15,8,
      8,5,12,9,12,5,14,6,8,13,6,5,15,13,11,11};
   localparam rmd_pkg::word_type LConst[5] = '{32'h0, 32'h5a827999, 32'h6ed9eba1,
      32'h8f1bbcdc, 32'ha953fd4e};
   localparam rmd_pkg::word_type RConst[5] = '{32'h50a28be6, 32'h5c4dd124,
      32'h6d703ef3, 32'h7a6d76e9, 32'h0};

   function new();
      chain  = IvTab;
      fill   = 0;
      errors = 0;
   endfunction

   static function rmd_pkg::word_type rol(rmd_pkg::word_type x, int n);
      return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
   endfunction

   static function rmd_pkg::word_type boolf(int g, rmd_pkg::word_type x,
                                            rmd_pkg::word_type y, rmd_pkg::word_type z);
      case (g)
         0: return x ^ y ^ z;
         1: return (x & y) | (~x & z);
         2: return (x | ~y) ^ z;
         3: return (x & z) | (y & ~z);
         default: return x ^ (y | ~z);
      endcase
   endfunction

   function void compress_block();
      rmd_pkg::word_type a, b, c, d, e, a2, b2, c2, d2, e2, t;
      int g;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      a2 = a; b2 = b; c2 = c; d2 = d; e2 = e;
      for (int j = 0; j < 80; j++) begin
         g = j / 16;
         t = a + boolf(g, b, c, d) + words[LWord[j]] + LConst[g];
         t = rol(t, LRot[j]) + e;
         a = e; e = d; d = rol(c, 10); c = b; b = t;
         t = a2 + boolf(4 - g, b2, c2, d2) + words[RWord[j]] + RConst[g];
         t = rol(t, RRot[j]) + e2;
         a2 = e2; e2 = d2; d2 = rol(c2, 10); c2 = b2; b2 = t;
      end
      t        = chain[1] + c + d2;
      chain[1] = chain[2] + d + e2;
      chain[2] = chain[3] + e + a2;
      chain[3] = chain[4] + a + b2;
      chain[4] = chain[0] + b + c2;
      chain[0] = t;
   endfunction

   // Note one accepted word; queue a digest when it closes a block.
   function void note_word(rmd_pkg::req_type w);
      rmd_pkg::rsp_type r;
      if (w.new_message) begin
         chain = IvTab;
         fill  = 0;
      end
      words[fill] = w.msg_word;
      fill = (fill + 1) % 16;
      if (fill == 0) begin
         compress_block();
         r = '{chain[0], chain[1], chain[2], chain[3], chain[4]};
         pending.push_back(r);
      end
   endfunction

   function void check_digest(rmd_pkg::rsp_type got);
      rmd_pkg::rsp_type want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected digest %h", $time, got);
         errors++;
         return;
      end
      want = pending.pop_front();
      if (got.hash_w0 !== want.hash_w0) begin
         $display("%0t: hash_w0 expected %h actual %h", $time, want.hash_w0, got.hash_w0);
         errors++;
      end
      if (got.hash_w1 !== want.hash_w1) begin
         $display("%0t: hash_w1 expected %h actual %h", $time, want.hash_w1, got.hash_w1);
         errors++;
      end
      if (got.hash_w2 !== want.hash_w2) begin
         $display("%0t: hash_w2 expected %h actual %h", $time, want.hash_w2, got.hash_w2);
         errors++;
      end
      if (got.hash_w3 !== want.hash_w3) begin
         $display("%0t: hash_w3 expected %h actual %h", $time, want.hash_w3, got.hash_w3);
         errors++;
      end
      if (got.hash_w4 !== want.hash_w4) begin
         $display("%0t: hash_w4 expected %h actual %h", $time, want.hash_w4, got.hash_w4);
         errors++;
      end
   endfunction
endclass

module tb_ripemd160_block_compress;
   import rmd_pkg::*;

   localparam int StallLimit = 20000;

   logic clock;
   logic reset;
   int   idle_cycles;
   int   gap_left;
   bit   quiet_rsp;

   rmd_stream_if #(.payload_type(req_type)) req ();
   rmd_stream_if #(.payload_type(rsp_type)) rsp ();

   digest_board board;

   ripemd160_block_compress dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Score both channels at the edge where the transfer happens.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) board.note_word(req.payload);
      if (!reset && rsp.valid && rsp.ready) board.check_digest(rsp.payload);
   end

   // Receiver: either run wide open for a while or stall on a random pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) quiet_rsp = ~quiet_rsp;
         rsp.ready <= quiet_rsp ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // Watchdog: count cycles with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Present one word and hold it until the transfer. Valid stays high after
   // the transfer; the next word, a gap or a drain drives it in that same step.
   task automatic send_word(input word_type w, input logic nm);
      if (gap_left == 0 && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 12);
      while (gap_left > 0) begin
         req.valid <= 1'b0;
         @(posedge clock);
         gap_left--;
      end
      req.valid   <= 1'b1;
      req.payload <= '{msg_word: w, new_message: nm};
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic send_block(input logic first_new, input int kind);
      word_type w;
      for (int i = 0; i < 16; i++) begin
         case (kind)
            0: w = 32'h0;
            1: w = 32'hffffffff;
            2: w = (i % 2) ? 32'h55555555 : 32'haaaaaaaa;
            default: w = $urandom;
         endcase
         send_word(w, (i == 0) ? first_new : 1'b0);
      end
   endtask

   task automatic drain_digests();
      req.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int sent;
      int len;
      board       = new();
      idle_cycles = 0;
      gap_left    = 0;
      quiet_rsp   = 1'b0;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.payload = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: all-zero, all-one and alternating blocks, the second chained.
      send_block(1'b0, 0);
      send_block(1'b0, 1);
      send_block(1'b1, 2);
      // Partial block then restart: the dropped words must not leak in.
      for (int i = 0; i < 5; i++) send_word($urandom, 1'b0);
      send_block(1'b1, 3);
      // Hold off until every digest is out.
      drain_digests();

      // Random: mostly whole multi-block messages, some broken restarts.
      sent = 0;
      while (sent < 960) begin
         if ($urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, 15);
            for (int i = 0; i < len; i++) send_word($urandom, (i == 0));
            sent += len;
         end else begin
            len = $urandom_range(1, 3);
            for (int b = 0; b < len; b++) send_block((b == 0) && $urandom_range(0, 1), 3);
            sent += 16 * len;
         end
         if ($urandom_range(0, 15) == 0) drain_digests();
      end
      // Close any partial block so nothing is left half-filled.
      while (board.fill != 0) send_word($urandom, 1'b0);

      drain_digests();
      repeat (100) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
